// ----- design/assert_macros.svh -----
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check that a condition implies a consequence at the same edge
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// check that a condition implies a consequence at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- design/kabf_pkg.sv -----
// ----------------------------------------------------------------------------
// kabf_pkg
// shared types, constants and helpers of the angle/bias kalman filter
// ----------------------------------------------------------------------------
package kabf_pkg;

  localparam int unsigned RegW = 31;
  localparam int unsigned WordW = 32;
  localparam int unsigned DtW = 20;
  localparam int unsigned WideW = 64;

  localparam logic [RegW-1:0] QAngleReset = 31'd16777;
  localparam logic [RegW-1:0] QBiasReset = 31'd50332;
  localparam logic [RegW-1:0] RReset = 31'd503316;

  localparam logic [1:0] RegQAngle = 2'd0;
  localparam logic [1:0] RegQBias = 2'd1;
  localparam logic [1:0] RegR = 2'd2;

  // datapath operations, one per controller step
  localparam int unsigned OpW = 5;
  localparam logic [OpW-1:0] OpLoad = 5'd0;   // latch inputs, rate = sat(mrate - bias)
  localparam logic [OpW-1:0] OpAng = 5'd1;    // angle += rnd(dt*rate,16)
  localparam logic [OpW-1:0] OpT = 5'd2;      // t = rnd(dt*P11,16)
  localparam logic [OpW-1:0] OpSum = 5'd3;    // sum = t - P01 - P10 + Qa
  localparam logic [OpW-1:0] OpP00 = 5'd4;    // P00 += rnd(dt*sum,16), sum split in two
  localparam logic [OpW-1:0] OpP00b = 5'd5;
  localparam logic [OpW-1:0] OpCross = 5'd6;  // P01,P10 -= t
  localparam logic [OpW-1:0] OpP11 = 5'd7;    // P11 += rnd(Qb*dt,16)
  localparam logic [OpW-1:0] OpDivSt = 5'd8;  // start divisions, y = sat(meas - angle)
  localparam logic [OpW-1:0] OpDivK0 = 5'd9;  // divider step for k0
  localparam logic [OpW-1:0] OpDivK1 = 5'd10; // divider step for k1
  localparam logic [OpW-1:0] OpK0 = 5'd11;    // finish k0
  localparam logic [OpW-1:0] OpK1 = 5'd12;    // finish k1
  localparam logic [OpW-1:0] OpUAng = 5'd13;
  localparam logic [OpW-1:0] OpUBias = 5'd14;
  localparam logic [OpW-1:0] OpU00 = 5'd15;
  localparam logic [OpW-1:0] OpU01 = 5'd16;
  localparam logic [OpW-1:0] OpU10 = 5'd17;
  localparam logic [OpW-1:0] OpU11 = 5'd18;
  localparam logic [OpW-1:0] OpNop = 5'd19;

  // divider: 57-bit magnitude quotient, one bit per step
  localparam int unsigned QuoW = 57;
  localparam int unsigned DivCntW = 6;

  typedef struct packed {
    logic           en;
    logic [OpW-1:0] op;
  } kabf_cmd_t;

  typedef struct packed {
    logic div_done;
  } kabf_stat_t;

  function automatic logic [WordW-1:0] sat32(input logic signed [WideW-1:0] v);
    logic [WordW-1:0] r;
    if (v > 64'sd2147483647) r = 32'h7fff_ffff;
    else if (v < -64'sd2147483648) r = 32'h8000_0000;
    else r = v[WordW-1:0];
    return r;
  endfunction

  // add half then arithmetic shift: floor rounding with halves up
  function automatic logic signed [WideW-1:0] rnd16(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] a;
    a = v + 64'sd32768;
    return a >>> 16;
  endfunction

  function automatic logic signed [WideW-1:0] rnd24(input logic signed [WideW-1:0] v);
    logic signed [WideW-1:0] a;
    a = v + 64'sd8388608;
    return a >>> 24;
  endfunction

endpackage

// ----- design/kabf_ctrl.sv -----
// ----------------------------------------------------------------------------
// kabf_ctrl
// sequencer: steps the datapath through predict, divide and update
// ----------------------------------------------------------------------------
module kabf_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  kabf_pkg::kabf_stat_t stat,
  input  logic                out_free,
  output kabf_pkg::kabf_cmd_t cmd,
  output logic                busy,
  output logic                done
);

  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StRun = 2'd1;
  localparam logic [1:0] StDivA = 2'd2;
  localparam logic [1:0] StDivB = 2'd3;

  logic [1:0]              state_r, state_nxt;
  logic [kabf_pkg::OpW-1:0] op_r, op_nxt;

  always_comb begin
    state_nxt = state_r;
    op_nxt = op_r;
    cmd.en = 1'b0;
    cmd.op = kabf_pkg::OpNop;
    done = 1'b0;
    unique case (state_r)
      StIdle: begin
        if (start) begin
          cmd.en = 1'b1;
          cmd.op = kabf_pkg::OpLoad;
          op_nxt = kabf_pkg::OpAng;
          state_nxt = StRun;
        end
      end
      StRun: begin
        if (op_r == kabf_pkg::OpK0) begin
          // wait for output slot before committing
          if (out_free) begin
            cmd.en = 1'b1;
            cmd.op = op_r;
            op_nxt = op_r + 5'd1;
          end
        end else begin
          cmd.en = 1'b1;
          cmd.op = op_r;
          if (op_r == kabf_pkg::OpDivSt) begin
            state_nxt = StDivA;
          end else if (op_r == kabf_pkg::OpU11) begin
            done = 1'b1;
            state_nxt = StIdle;
          end else begin
            op_nxt = op_r + 5'd1;
          end
        end
      end
      StDivA: begin
        cmd.en = 1'b1;
        cmd.op = kabf_pkg::OpDivK0;
        state_nxt = StDivB;
      end
      StDivB: begin
        cmd.en = 1'b1;
        cmd.op = kabf_pkg::OpDivK1;
        if (stat.div_done) begin
          op_nxt = kabf_pkg::OpK0;
          state_nxt = StRun;
        end else begin
          state_nxt = StDivA;
        end
      end
      default: state_nxt = StIdle;
    endcase
  end

  assign busy = (state_r != StIdle);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= StIdle;
      op_r <= kabf_pkg::OpNop;
    end else begin
      state_r <= state_nxt;
      op_r <= op_nxt;
    end
  end

endmodule

// ----- design/kabf_dp.sv -----
// ----------------------------------------------------------------------------
// kabf_dp
// datapath: state registers, one shared multiplier, restoring divider
// ----------------------------------------------------------------------------
module kabf_dp (
  input  logic                       clk,
  input  logic                       rst_n,
  input  kabf_pkg::kabf_cmd_t        cmd,
  output kabf_pkg::kabf_stat_t       stat,
  input  logic [kabf_pkg::WordW-1:0] in_meas,
  input  logic [kabf_pkg::WordW-1:0] in_rate,
  input  logic [kabf_pkg::DtW-1:0]   in_dt,
  input  logic                       cfg_we,
  input  logic [1:0]                 cfg_idx,
  input  logic [kabf_pkg::WordW-1:0] cfg_val,
  output logic [kabf_pkg::WordW-1:0] angle,
  output logic [kabf_pkg::WordW-1:0] bias
);

  localparam int unsigned W = kabf_pkg::WordW;
  localparam int unsigned L = kabf_pkg::WideW;
  localparam int unsigned Q = kabf_pkg::QuoW;

  logic [kabf_pkg::RegW-1:0] qa_r, qb_r, rn_r;
  logic [W-1:0] ang_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  logic [W-1:0] meas_r, rate_r, y_r, k0_r, k1_r;
  logic [kabf_pkg::DtW-1:0] dt_r;
  logic signed [L-1:0] t_r, sum_r, pacc_r;
  // divider
  logic [Q-1:0] n0_r, n1_r, q0_r, q1_r;
  logic [33:0]  r0_r, r1_r, dv_r;
  logic         s0_r, s1_r, dz_r;
  logic [kabf_pkg::DivCntW-1:0] cnt_r;

  // shared multiplier, 33x33 signed
  logic signed [32:0] ma, mb;
  logic signed [65:0] mp;
  logic signed [L-1:0] prod;

  always_comb begin
    ma = '0;
    mb = '0;
    case (cmd.op)
      kabf_pkg::OpAng:   begin ma = {13'd0, dt_r}; mb = {rate_r[W-1], rate_r}; end
      kabf_pkg::OpT:     begin ma = {13'd0, dt_r}; mb = {p11_r[W-1], p11_r}; end
      kabf_pkg::OpP00:   begin ma = {13'd0, dt_r}; mb = {1'b0, sum_r[31:0]}; end
      kabf_pkg::OpP00b:  begin ma = {13'd0, dt_r}; mb = {sum_r[L-1], sum_r[L-1:W]}; end
      kabf_pkg::OpP11:   begin ma = {13'd0, dt_r}; mb = {2'b00, qb_r}; end
      kabf_pkg::OpUAng:  begin ma = {k0_r[W-1], k0_r}; mb = {y_r[W-1], y_r}; end
      kabf_pkg::OpUBias: begin ma = {k1_r[W-1], k1_r}; mb = {y_r[W-1], y_r}; end
      kabf_pkg::OpU00:   begin ma = {k0_r[W-1], k0_r}; mb = {p00_r[W-1], p00_r}; end
      kabf_pkg::OpU01:   begin ma = {k0_r[W-1], k0_r}; mb = {p01_r[W-1], p01_r}; end
      kabf_pkg::OpU10:   begin ma = {k1_r[W-1], k1_r}; mb = {p00_r[W-1], p00_r}; end
      // pre-update p01 was saved in sum_r
      kabf_pkg::OpU11:   begin ma = {k1_r[W-1], k1_r}; mb = sum_r[32:0]; end
      default: ;
    endcase
  end

  assign mp = ma * mb;
  assign prod = mp[L-1:0];

  function automatic logic signed [L-1:0] sx(input logic [W-1:0] v);
    return {{(L-W){v[W-1]}}, v};
  endfunction

  // divider step helpers
  function automatic logic [33+Q:0] dstep(input logic [33:0] r, input logic [Q-1:0] n,
                                          input logic [33:0] d);
    logic [34:0] sh;
    logic [34:0] df;
    logic [33:0] rn;
    logic        qb;
    sh = {r, n[Q-1]};
    df = sh - {1'b0, d};
    if (!df[34]) begin
      rn = df[33:0];
      qb = 1'b1;
    end else begin
      rn = sh[33:0];
      qb = 1'b0;
    end
    return {rn, n[Q-2:0], qb};
  endfunction

  function automatic logic [W-1:0] dfin(input logic [Q-1:0] q, input logic s,
                                        input logic z);
    logic signed [L-1:0] v;
    v = {{(L-Q){1'b0}}, q};
    if (s) v = -v;
    return z ? '0 : kabf_pkg::sat32(v);
  endfunction

  logic signed [L-1:0] s_w, a0, a1;
  logic [33+Q:0] st0, st1;

  always_comb begin
    s_w = sx(p00_r) + {33'd0, rn_r};
    a0 = sx(p00_r);
    if (a0 < 0) a0 = -a0;
    a1 = sx(p10_r);
    if (a1 < 0) a1 = -a1;
    st0 = dstep(r0_r, n0_r, dv_r);
    st1 = dstep(r1_r, n1_r, dv_r);
  end

  assign stat.div_done = (cnt_r == kabf_pkg::DivCntW'(Q - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      qa_r <= kabf_pkg::QAngleReset;
      qb_r <= kabf_pkg::QBiasReset;
      rn_r <= kabf_pkg::RReset;
      ang_r <= '0;
      bias_r <= '0;
      p00_r <= '0;
      p01_r <= '0;
      p10_r <= '0;
      p11_r <= '0;
      cnt_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx)
          kabf_pkg::RegQAngle: qa_r <= cfg_val[kabf_pkg::RegW-1:0];
          kabf_pkg::RegQBias:  qb_r <= cfg_val[kabf_pkg::RegW-1:0];
          kabf_pkg::RegR:      rn_r <= cfg_val[kabf_pkg::RegW-1:0];
          default: ;
        endcase
      end
      if (cmd.en) begin
        case (cmd.op)
          kabf_pkg::OpLoad: begin
            meas_r <= in_meas;
            dt_r <= in_dt;
            rate_r <= kabf_pkg::sat32(sx(in_rate) - sx(bias_r));
          end
          kabf_pkg::OpAng: ang_r <= kabf_pkg::sat32(sx(ang_r) + kabf_pkg::rnd16(prod));
          kabf_pkg::OpT: t_r <= kabf_pkg::rnd16(prod);
          kabf_pkg::OpSum: sum_r <= t_r - sx(p01_r) - sx(p10_r) + {33'd0, qa_r};
          // dt*sum = dt*lo + dt*hi*2^32, accumulated exactly
          kabf_pkg::OpP00: pacc_r <= prod;
          kabf_pkg::OpP00b: p00_r <= kabf_pkg::sat32(sx(p00_r) +
                                       kabf_pkg::rnd16(pacc_r + (prod <<< 32)));
          kabf_pkg::OpCross: begin
            p01_r <= kabf_pkg::sat32(sx(p01_r) - t_r);
            p10_r <= kabf_pkg::sat32(sx(p10_r) - t_r);
          end
          kabf_pkg::OpP11: p11_r <= kabf_pkg::sat32(sx(p11_r) + kabf_pkg::rnd16(prod));
          kabf_pkg::OpDivSt: begin
            y_r <= kabf_pkg::sat32(sx(meas_r) - sx(ang_r));
            dz_r <= (s_w == 0);
            s0_r <= p00_r[W-1] ^ s_w[L-1];
            s1_r <= p10_r[W-1] ^ s_w[L-1];
            dv_r <= s_w[L-1] ? 34'(-s_w) : s_w[33:0];
            n0_r <= {a0[32:0], 24'd0};
            n1_r <= {a1[32:0], 24'd0};
            r0_r <= '0;
            r1_r <= '0;
            cnt_r <= '0;
          end
          kabf_pkg::OpDivK0: begin
            r0_r <= st0[33+Q:Q];
            n0_r <= st0[Q-1:0];
          end
          kabf_pkg::OpDivK1: begin
            r1_r <= st1[33+Q:Q];
            n1_r <= st1[Q-1:0];
            cnt_r <= cnt_r + 6'd1;
          end
          kabf_pkg::OpK0: k0_r <= dfin(n0_r, s0_r, dz_r);
          kabf_pkg::OpK1: k1_r <= dfin(n1_r, s1_r, dz_r);
          kabf_pkg::OpUAng: ang_r <= kabf_pkg::sat32(sx(ang_r) + kabf_pkg::rnd24(prod));
          kabf_pkg::OpUBias: bias_r <= kabf_pkg::sat32(sx(bias_r) + kabf_pkg::rnd24(prod));
          kabf_pkg::OpU00: t_r <= kabf_pkg::rnd24(prod);
          kabf_pkg::OpU01: begin
            p01_r <= kabf_pkg::sat32(sx(p01_r) - kabf_pkg::rnd24(prod));
            sum_r <= sx(p01_r);
          end
          kabf_pkg::OpU10: begin
            p10_r <= kabf_pkg::sat32(sx(p10_r) - kabf_pkg::rnd24(prod));
            p00_r <= kabf_pkg::sat32(sx(p00_r) - t_r);
          end
          kabf_pkg::OpU11: p11_r <= kabf_pkg::sat32(sx(p11_r) - kabf_pkg::rnd24(prod));
          default: ;
        endcase
      end
    end
  end

  assign angle = ang_r;
  assign bias = bias_r;

endmodule

// ----- design/kalman_angle_bias_filter.sv -----
// time from input transfer to result valid is dominated by the divider steps; both
// gains share the restoring divider loop
// one item is processed at a time
// a finished result waits in the output register while the next item runs
// reset: rst_n synchronous active low; state cleared, noise registers to defaults
// ----------------------------------------------------------------------------
// kalman_angle_bias_filter
// two-state angle/bias kalman filter, shared multiplier and serial divider
// ----------------------------------------------------------------------------
module kalman_angle_bias_filter (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [87:0] in_tdata,   // measured_angle, measured_rate, time_step, zero pad
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,  // filtered_angle, rate_bias
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  kabf_pkg::kabf_cmd_t  cmd;
  kabf_pkg::kabf_stat_t stat;
  logic busy, done, start;
  logic [31:0] angle, bias;
  logic        ovalid_r;
  logic [63:0] odata_r;
  logic        out_free;

  // output slot is free when empty or drained this cycle
  assign out_free = !ovalid_r || out_tready;
  assign in_tready = !busy;
  assign start = in_tvalid && in_tready;
  assign cfg_ready = 1'b1;

  kabf_ctrl u_ctrl (
    .clk, .rst_n, .start, .stat, .out_free, .cmd, .busy, .done
  );

  kabf_dp u_dp (
    .clk, .rst_n, .cmd, .stat,
    .in_meas(in_tdata[31:0]),
    .in_rate(in_tdata[63:32]),
    .in_dt(in_tdata[83:64]),
    .cfg_we(cfg_valid),
    .cfg_idx(cfg_index),
    .cfg_val(cfg_data),
    .angle, .bias
  );

  // result register; filled once the last covariance write lands. angle and
  // bias are already final after the bias step, loaded here on done.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovalid_r <= 1'b0;
    end else if (done) begin
      ovalid_r <= 1'b1;
    end else if (out_tready) begin
      ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) odata_r <= {bias, angle};
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata = odata_r;

endmodule

// ----- design/kabf_checker.sv -----
// ----------------------------------------------------------------------------
// kabf_checker
// port-level checks of the filter's handshakes
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module kabf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [63:0] out_tdata
);

  `ASSERT_NEXT(a_busy_after_take, clk, rst_n, in_tvalid && in_tready, !in_tready)
  `ASSERT_NEXT(a_no_out_soon, clk, rst_n, in_tvalid && in_tready, !($rose(out_tvalid)))
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
               out_tvalid && $stable(out_tdata))

endmodule

bind kalman_angle_bias_filter kabf_checker u_kabf_checker (
  .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready, .out_tdata
);
